// ===== rtl/core/boe_pkg.sv =====
// Package: shared widths, constants and tables of the body orientation estimator.
package boe_pkg;

   localparam int CoordWidth   = 15;
   localparam int AngleWidth   = 16;
   localparam int ThreshWidth  = 14;
   localparam int BodyWidth    = 14;
   localparam int OffsetWidth  = 16;
   localparam int ClassWidth   = 2;
   localparam int UserWidth    = 3;
   localparam int DefMaxUsers  = 8;
   localparam int DefTaps      = 7;
   localparam int CordicSteps  = 16;
   localparam int CordicWidth  = 36;
   localparam int AccWidth     = 26;
   localparam int AngleLimit   = 11520;
   localparam int QuarterTurn  = 5760;
   localparam int HalfTurn     = 11520;
   localparam logic [ThreshWidth-1:0] WideReset = 14'd2240;
   localparam logic [ThreshWidth-1:0] NearReset = 14'd1280;

   localparam int CsrAddrWidth = 3;
   localparam logic [CsrAddrWidth-1:0] AddrWide = 3'd0;
   localparam logic [CsrAddrWidth-1:0] AddrNear = 3'd4;

   localparam logic [ClassWidth-1:0] ClassNone    = 2'd0;
   localparam logic [ClassWidth-1:0] ClassAway    = 2'd1;
   localparam logic [ClassWidth-1:0] ClassPartial = 2'd2;
   localparam logic [ClassWidth-1:0] ClassFacing  = 2'd3;

   // empty_frame travels on tuser, so tdata holds the user and the six coordinates
   localparam int ReqWidth = UserWidth + 6 * CoordWidth;
   localparam int ReqBytes = (ReqWidth + 7) / 8 * 8;
   localparam int RspWidth = UserWidth + BodyWidth + ClassWidth + OffsetWidth;
   localparam int RspBytes = (RspWidth + 7) / 8 * 8;

   // Start/done between the top sequencer and the atan2 unit.
   typedef struct packed {
      logic                          start;
      logic signed [CoordWidth:0]    y;
      logic signed [CoordWidth:0]    x;
   } atan_req_type;

   typedef struct packed {
      logic                          done;
      logic signed [AngleWidth-1:0]  angle;
   } atan_rsp_type;

   function automatic logic [AccWidth-1:0] atan_entry(input logic [3:0] i);
      logic [AccWidth-1:0] v;
      unique case (i)
         4'd0:  v = 26'd2949120;
         4'd1:  v = 26'd1740967;
         4'd2:  v = 26'd919879;
         4'd3:  v = 26'd466945;
         4'd4:  v = 26'd234379;
         4'd5:  v = 26'd117304;
         4'd6:  v = 26'd58666;
         4'd7:  v = 26'd29335;
         4'd8:  v = 26'd14668;
         4'd9:  v = 26'd7334;
         4'd10: v = 26'd3667;
         4'd11: v = 26'd1833;
         4'd12: v = 26'd917;
         4'd13: v = 26'd458;
         4'd14: v = 26'd229;
         default: v = 26'd115;
      endcase
      return v;
   endfunction

   function automatic logic [14:0] gauss_tap(input logic [2:0] j);
      logic [14:0] v;
      unique case (j)
         3'd0: v = 15'd290;
         3'd1: v = 15'd3539;
         3'd2: v = 15'd15862;
         3'd3: v = 15'd26154;
         3'd4: v = 15'd15862;
         3'd5: v = 15'd3539;
         3'd6: v = 15'd290;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/boe_atan2.sv =====
// Iterative 16-step vectoring CORDIC atan2 in 1/64 degree.
module boe_atan2 (
   input  logic                 clock,
   input  logic                 reset,
   input  boe_pkg::atan_req_type req,
   output boe_pkg::atan_rsp_type rsp
);
   import boe_pkg::*;

   logic signed [CordicWidth-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [AccWidth-1:0]    acc_ff, acc_in;
   logic [3:0]                    step_ff, step_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          zero_ff, zero_in;
   logic signed [AngleWidth-1:0]  angle_ff, angle_in;

   logic signed [CordicWidth-1:0] xs, ys, x0, y0;
   logic signed [AccWidth-1:0]    acc_done, acc_abs, a0;
   logic [AccWidth-1:0]           mag;

   // arithmetic shift is a floor shift
   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;

   always_comb begin
      x0 = CordicWidth'(req.x) <<< 14;
      y0 = CordicWidth'(req.y) <<< 14;
      a0 = '0;
      if (req.x < 0) begin
         a0 = (req.y >= 0) ? AccWidth'(180 * 65536) : -AccWidth'(180 * 65536);
         x0 = -x0;
         y0 = -y0;
      end
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      acc_in = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      angle_in = angle_ff;
      acc_done = acc_ff;
      acc_abs = '0;
      mag = '0;
      if (req.start) begin
         x_in = x0;
         y_in = y0;
         acc_in = a0;
         step_in = '0;
         busy_in = 1'b1;
         zero_in = (req.x == 0) && (req.y == 0);
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            acc_done = acc_ff + $signed(atan_entry(step_ff));
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            acc_done = acc_ff - $signed(atan_entry(step_ff));
         end
         acc_in = acc_done;
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(CordicSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            acc_abs = (acc_done < 0) ? -acc_done : acc_done;
            mag = (AccWidth'(acc_abs) + AccWidth'(512)) >> 10;
            if (mag > AccWidth'(AngleLimit)) mag = AccWidth'(AngleLimit);
            if (zero_ff) angle_in = '0;
            else if (acc_done < 0) angle_in = -$signed(mag[AngleWidth-1:0]);
            else angle_in = $signed(mag[AngleWidth-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      acc_ff <= acc_in;
      zero_ff <= zero_in;
      angle_ff <= angle_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.angle = angle_ff;
endmodule

// ===== rtl/core/boe_history.sv =====
// Per-user angle history memory with ring addressing and the Gaussian MAC.
module boe_history #(
   parameter int MaxUsers = boe_pkg::DefMaxUsers,
   parameter int Taps     = boe_pkg::DefTaps
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [((MaxUsers > 1) ? $clog2(MaxUsers) : 1)-1:0] user,
   input  logic signed [boe_pkg::AngleWidth-1:0] theta,
   output logic                               done,
   output logic [boe_pkg::BodyWidth-1:0]      body
);
   import boe_pkg::*;

   localparam int UW    = (MaxUsers > 1) ? $clog2(MaxUsers) : 1;
   localparam int TW    = $clog2(Taps);
   localparam int Depth = MaxUsers * Taps;
   localparam int AW    = $clog2(Depth);
   localparam int SumW  = 36;

   // one-hot sequencer
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_MAC  = 4'b0100,
      S_DONE = 4'b1000
   } hist_state_type;

   logic signed [AngleWidth-1:0] mem [Depth];
   logic signed [AngleWidth-1:0] rd_ff;

   // per user: fill count and the ring slot of the oldest entry
   logic [TW:0]   count_ff [MaxUsers];
   logic [TW-1:0] head_ff  [MaxUsers];

   hist_state_type state_ff, state_in;
   logic [UW-1:0]  user_ff;
   logic [TW:0]    n_ff, n_in;
   logic [TW-1:0]  j_ff, j_in;
   logic [TW-1:0]  head_base_ff, head_base_in;
   logic signed [SumW-1:0] sum_ff, sum_in;
   logic [BodyWidth-1:0] body_ff, body_in;
   logic done_ff;

   logic           wr_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [TW-1:0]  slot, wslot;
   logic [TW:0]    slot_sum, wslot_sum;
   logic [UW-1:0]  u_sel;
   logic [TW:0]    cnt_cur;
   logic [TW-1:0]  head_cur;
   logic signed [SumW-1:0] prod, sabs;
   logic [SumW-1:0] rnd;

   assign u_sel    = UW'(user);
   assign cnt_cur  = count_ff[u_sel];
   assign head_cur = head_ff[u_sel];

   // ring slot for history index j, wrapped modulo Taps
   assign slot_sum = (TW+1)'(head_base_ff) + (TW+1)'(j_ff);
   assign slot = (slot_sum >= (TW+1)'(Taps)) ? TW'(slot_sum - (TW+1)'(Taps))
                                             : TW'(slot_sum);
   assign wslot_sum = (TW+1)'(head_cur) + cnt_cur;
   assign wslot = (cnt_cur < (TW+1)'(Taps))
                  ? ((wslot_sum >= (TW+1)'(Taps)) ? TW'(wslot_sum - (TW+1)'(Taps))
                                                  : TW'(wslot_sum))
                  : head_cur;

   assign wr_en   = start;
   assign wr_addr = AW'(u_sel * Taps + wslot);
   assign rd_addr = AW'(user_ff * Taps + slot);

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= theta;
      rd_ff <= mem[rd_addr];
   end

   assign prod = SumW'(rd_ff) * $signed({1'b0, gauss_tap(3'(j_ff))});

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      j_in = j_ff;
      head_base_in = head_base_ff;
      sum_in = sum_ff;
      body_in = body_ff;
      sabs = '0;
      rnd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_READ;
               j_in = '0;
               sum_in = '0;
               if (cnt_cur < (TW+1)'(Taps)) begin
                  n_in = cnt_cur + 1'b1;
                  head_base_in = head_cur;
               end else begin
                  n_in = (TW+1)'(Taps);
                  head_base_in = (head_cur == TW'(Taps - 1)) ? '0 : head_cur + 1'b1;
               end
            end
         end
         S_READ: state_in = S_MAC;
         S_MAC: begin
            sum_in = sum_ff + prod;
            if ((TW+1)'(j_ff) + 1'b1 >= n_ff) begin
               state_in = S_DONE;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_DONE: begin
            sabs = (sum_ff < 0) ? -sum_ff : sum_ff;
            rnd = (SumW'(sabs) + SumW'(32768)) >> 16;
            body_in = (rnd > SumW'(AngleLimit)) ? BodyWidth'(AngleLimit)
                                                : rnd[BodyWidth-1:0];
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
         for (int u = 0; u < MaxUsers; u++) begin
            count_ff[u] <= '0;
            head_ff[u] <= '0;
         end
      end else begin
         state_ff <= state_in;
         done_ff <= (state_ff == S_DONE);
         if (start) begin
            if (cnt_cur < (TW+1)'(Taps)) count_ff[u_sel] <= cnt_cur + 1'b1;
            else head_ff[u_sel] <= (head_cur == TW'(Taps - 1)) ? '0 : head_cur + 1'b1;
         end
      end
      if (start) user_ff <= u_sel;
      n_ff <= n_in;
      j_ff <= j_in;
      head_base_ff <= head_base_in;
      sum_ff <= sum_in;
      body_ff <= body_in;
   end

   assign done = done_ff;
   assign body = body_ff;
endmodule

// ===== rtl/core/body_orientation_estimator.sv =====
// Top level: stream handshake, sequencer, classification and held state.
// One item is worked at a time through a shared 16-step CORDIC atan2 unit
// (shoulders, then neck on user 0) and a walk of the n history taps of the
// user (n = 1..7, the fill after this item), one memory read and one
// multiply-accumulate per tap. An empty frame or an out-of-range user goes
// straight to the result register; other users, and user 0 with the neck
// at the origin, load it after the shoulder atan2 and the history walk,
// and user 0 otherwise adds the neck atan2 and the classification. A new
// item is accepted only once the result is loaded, never while one is in
// flight; a result not taken stalls only the last step of the next item.
// Registers at 0x0 (wide threshold) and 0x4 (near threshold), 14 bits each.
module body_orientation_estimator #(
   parameter int MaxUsers = boe_pkg::DefMaxUsers,
   parameter int Taps     = boe_pkg::DefTaps
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // empty_frame
   input  logic                           req_tuser,
   // user_index, left_shoulder_x, left_shoulder_z,
   // right_shoulder_x, right_shoulder_z, neck_x, neck_z
   input  logic [boe_pkg::ReqBytes-1:0]   req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // echo_user, body_angle, direction_class, direction_offset
   output logic [boe_pkg::RspBytes-1:0]   rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [boe_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import boe_pkg::*;

   localparam int UW = (MaxUsers > 1) ? $clog2(MaxUsers) : 1;

   typedef enum logic [6:0] {
      T_IDLE = 7'b0000001,
      T_BODY = 7'b0000010,
      T_HIST = 7'b0000100,
      T_NECK = 7'b0001000,
      T_CLS  = 7'b0010000,
      T_OUT  = 7'b0100000,
      T_WAIT = 7'b1000000
   } top_state_type;

   top_state_type state_ff, state_in;
   logic [ThreshWidth-1:0] wide_ff, near_ff;
   logic [ClassWidth-1:0]  hclass_ff, hclass_in;
   logic signed [OffsetWidth-1:0] hoff_ff, hoff_in;
   logic [ReqBytes-1:0]    item_ff;
   logic                   empty_ff;
   logic [BodyWidth-1:0]   body_ff, body_in;
   logic                   ovalid_ff, ovalid_in;
   logic [RspBytes-1:0]    odata_ff, odata_in;

   logic                   req_acc, csr_wr;
   logic                   i_empty;
   logic [UserWidth-1:0]   i_user;
   logic signed [CoordWidth-1:0] lx, lz, rx, rz, nx, nz;
   logic                   user_ok;
   atan_req_type           areq;
   atan_req_type           areq_q;
   atan_rsp_type           arsp;
   logic                   go_body_ff, go_neck_ff;
   logic                   h_start, h_done;
   logic [BodyWidth-1:0]   h_body;
   logic signed [AngleWidth+1:0] b_adj, off_w, off_abs;
   logic                   out_free;

   assign i_empty = empty_ff;
   assign i_user  = item_ff[2:0];
   assign lx = item_ff[3 +: CoordWidth];
   assign lz = item_ff[18 +: CoordWidth];
   assign rx = item_ff[33 +: CoordWidth];
   assign rz = item_ff[48 +: CoordWidth];
   assign nx = item_ff[63 +: CoordWidth];
   assign nz = item_ff[78 +: CoordWidth];
   assign user_ok = (32'(i_user) < MaxUsers);

   assign req_tready = (state_ff == T_IDLE);
   assign req_acc = req_tvalid && req_tready;
   assign out_free = !ovalid_ff || rsp_tready;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      unique case (csr_paddr)
         AddrWide: csr_prdata = 32'(wide_ff);
         AddrNear: csr_prdata = 32'(near_ff);
         default:  csr_prdata = '0;
      endcase
   end

   always_comb begin
      areq.start = 1'b0;
      areq.y = (CoordWidth+1)'(rx) - (CoordWidth+1)'(lx);
      areq.x = (CoordWidth+1)'(rz) - (CoordWidth+1)'(lz);
      // neck operands stay up through the cycle of the start pulse
      if (state_ff == T_HIST || state_ff == T_NECK) begin
         areq.y = (nx < 0) ? -(CoordWidth+1)'(nx) : (CoordWidth+1)'(nx);
         areq.x = (CoordWidth+1)'(nz);
      end
   end

   // start pulses are registered so operands are stable from the item latch
   always_comb begin
      areq_q = areq;
      areq_q.start = go_body_ff || go_neck_ff;
   end

   boe_atan2 u_atan (
      .clock(clock), .reset(reset),
      .req(areq_q), .rsp(arsp)
   );

   assign h_start = (state_ff == T_BODY) && arsp.done;

   boe_history #(.MaxUsers(MaxUsers), .Taps(Taps)) u_hist (
      .clock(clock), .reset(reset),
      .start(h_start), .user(UW'(i_user)), .theta(arsp.angle),
      .done(h_done), .body(h_body)
   );

   always_comb begin
      b_adj = (nx > 0) ? (AngleWidth+2)'(HalfTurn) - (AngleWidth+2)'(body_ff)
                       : (AngleWidth+2)'(body_ff);
      off_w = (AngleWidth+2)'(QuarterTurn) - (AngleWidth+2)'(arsp.angle) - b_adj;
      off_abs = (off_w < 0) ? -off_w : off_w;
   end

   always_comb begin
      state_in = state_ff;
      hclass_in = hclass_ff;
      hoff_in = hoff_ff;
      body_in = body_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in = odata_ff;
      unique case (state_ff)
         T_IDLE: if (req_acc) state_in = T_WAIT;
         T_WAIT: begin
            if (i_empty) begin
               hclass_in = ClassNone;
               body_in = '0;
               state_in = T_OUT;
            end else if (!user_ok) begin
               body_in = '0;
               state_in = T_OUT;
            end else begin
               state_in = T_BODY;
            end
         end
         T_BODY: if (arsp.done) state_in = T_HIST;
         T_HIST: begin
            if (h_done) begin
               body_in = h_body;
               if (i_user != '0) state_in = T_OUT;
               else if (nx == 0 && nz == 0) begin
                  hclass_in = ClassFacing;
                  hoff_in = '0;
                  state_in = T_OUT;
               end else state_in = T_NECK;
            end
         end
         T_NECK: if (arsp.done) state_in = T_CLS;
         T_CLS: begin
            hoff_in = OffsetWidth'(off_w);
            if (off_abs > (AngleWidth+2)'(wide_ff)) hclass_in = ClassAway;
            else if (off_abs > (AngleWidth+2)'(near_ff)) hclass_in = ClassPartial;
            else hclass_in = ClassFacing;
            state_in = T_OUT;
         end
         T_OUT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odata_in = RspBytes'({hoff_ff, hclass_ff, body_ff,
                                     i_empty ? UserWidth'(0) : i_user});
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         wide_ff <= WideReset;
         near_ff <= NearReset;
         hclass_ff <= ClassNone;
         hoff_ff <= '0;
         ovalid_ff <= 1'b0;
         go_body_ff <= 1'b0;
         go_neck_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hclass_ff <= hclass_in;
         hoff_ff <= hoff_in;
         ovalid_ff <= ovalid_in;
         go_body_ff <= (state_ff == T_WAIT) && !i_empty && user_ok;
         go_neck_ff <= (state_ff == T_HIST) && h_done && (i_user == '0)
                       && !(nx == 0 && nz == 0);
         if (csr_wr && csr_paddr == AddrWide) wide_ff <= csr_pwdata[ThreshWidth-1:0];
         if (csr_wr && csr_paddr == AddrNear) near_ff <= csr_pwdata[ThreshWidth-1:0];
      end
      if (req_acc) begin
         item_ff <= req_tdata;
         empty_ff <= req_tuser;
      end
      body_ff <= body_in;
      odata_ff <= odata_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
endmodule

// ===== rtl/core/boe_checker.sv =====
// Port-level checker for the body orientation estimator, bound to the top.
module boe_port_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [boe_pkg::RspBytes-1:0]  rsp_tdata,
   input logic                          csr_pready
);
   // one item at a time: no new acceptance right after one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted back to back");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // smoothed body angle never exceeds half a turn
   a_body_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16:3] <= 14'd11520)
      else $error("body angle out of range");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");
endmodule

bind body_orientation_estimator boe_port_checker u_boe_port_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .csr_pready(csr_pready)
);
